// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by sm3_hash
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/sm3_pkg.sv =====
// shared types, constants and functions of the sm3 hash block
package sm3_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic push;
		logic expand;
	} msg_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
	} rnd_ctrl_t;

	localparam hash_t SM3_IV = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	localparam word_t T_LOW       = 32'h79CC4519;
	// high round constant already rotated left by sixteen for round sixteen
	localparam word_t T_HIGH_R16  = 32'h9D8A7A87;
	localparam word_t PAD_WORD    = 32'h8000_0000;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [5:0] LAST_LOW_ROUND = 6'd15;
	localparam logic [3:0] LEN_HI_POS    = 4'd14;
	localparam logic [3:0] LAST_POS      = 4'd15;
	localparam logic [2:0] LAST_IDX      = 3'd7;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic word_t p0(input word_t x);
		return x ^ rotl(x, 9) ^ rotl(x, 17);
	endfunction

	function automatic word_t p1(input word_t x);
		return x ^ rotl(x, 15) ^ rotl(x, 23);
	endfunction

endpackage

// ===== hw/rtl/sm3_msg.sv =====
// block buffer as a 16-word shift window with message expansion
module sm3_msg import sm3_pkg::*; (
	input  logic      clk,
	input  msg_ctrl_t ctrl,
	input  word_t     push_word,
	output word_t     w_j,
	output word_t     wp_j
);

	word_t win_q [16];
	word_t w_new;

	// next expanded word from the sixteen most recent ones
	assign w_new = p1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 15))
		^ rotl(win_q[3], 7) ^ win_q[10];

	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.expand) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= ctrl.push ? push_word : w_new;
		end
	end

	assign w_j  = win_q[0];
	assign wp_j = win_q[0] ^ win_q[4];

endmodule

// ===== hw/rtl/sm3_round.sv =====
// sm3 compression round unit, one round per cycle while step is asserted
module sm3_round import sm3_pkg::*; (
	input  logic      clk,
	input  rnd_ctrl_t ctrl,
	input  logic [5:0] round,
	input  hash_t     chain,
	input  word_t     w_j,
	input  word_t     wp_j,
	output hash_t     state
);

	hash_t v_q;
	word_t t_q;
	word_t a12, ss1, ss2, ff, gg, tt1, tt2;
	logic  low;

	assign low = (round <= LAST_LOW_ROUND);
	assign a12 = rotl(v_q[0], 12);
	assign ss1 = rotl(a12 + v_q[4] + t_q, 7);
	assign ss2 = ss1 ^ a12;
	assign ff  = low ? (v_q[0] ^ v_q[1] ^ v_q[2])
		: ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
	assign gg  = low ? (v_q[4] ^ v_q[5] ^ v_q[6])
		: ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
	assign tt1 = ff + v_q[3] + ss2 + wp_j;
	assign tt2 = gg + v_q[7] + ss1 + w_j;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= chain;
			t_q <= T_LOW;
		end else if (ctrl.step) begin
			v_q[0] <= tt1;
			v_q[1] <= v_q[0];
			v_q[2] <= rotl(v_q[1], 9);
			v_q[3] <= v_q[2];
			v_q[4] <= p0(tt2);
			v_q[5] <= v_q[4];
			v_q[6] <= rotl(v_q[5], 19);
			v_q[7] <= v_q[6];
			// constant rotates by one per round, mod 32; after round fifteen it loads the pre-rotated high constant
			t_q <= (round == LAST_LOW_ROUND) ? T_HIGH_R16 : rotl(t_q, 1);
		end
	end

	assign state = v_q;

endmodule

// ===== hw/rtl/sm3_hash.sv =====
// sm3 hash top level: sequencer, chaining value, length counter, digest output
// a word that does not fill the block is only written into the buffer; a word that
// fills it adds 64 rounds on the shared round unit plus a fold
// a last word adds one padding word per remaining slot, one or two compressions,
// then 8 digest transfers
// async reset loads the initial vector and clears position, length and sequencer
`include "assert_macros.svh"

module sm3_hash import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PAD  = 5'b00010,
		S_COMP = 5'b00100,
		S_FOLD = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t      state_q;
	hash_t       chain_q;
	hash_t       rnd_state;
	logic [3:0]  pos_q;
	logic [60:0] bytes_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        pad_q;      // padding of the current message under way
	logic        pad_word_q; // marker word still to go after a full last word
	logic        len_hi_q;   // upper length word already in the buffer
	logic        done_q;     // lower length word in, digest follows compression

	logic        in_xfer, out_xfer;
	logic        push, full;
	word_t       push_word;
	word_t       w_j, wp_j;
	logic [2:0]  add_bytes;
	msg_ctrl_t   msg_ctrl;
	rnd_ctrl_t   rnd_ctrl;

	assign data_ready   = (state_q == S_IDLE);
	assign digest_valid = (state_q == S_OUT);
	assign in_xfer      = data_valid && data_ready;
	assign out_xfer     = digest_valid && digest_ready;

	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_IDX);

	// bytes taken by this transfer: four for an inner word; on a last word counts of five and up act as four
	assign add_bytes = (!last || byte_count[2]) ? 3'd4 : byte_count;

	// word going into the block buffer this cycle
	always_comb begin
		push      = 1'b0;
		push_word = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					push = 1'b1;
					if (!last || byte_count[2]) begin
						push_word = data_word;
					end else begin
						// keep the leading bytes, marker right after them
						case (byte_count[1:0])
							2'd0:    push_word = PAD_WORD;
							2'd1:    push_word = {data_word[31:24], 24'h80_0000};
							2'd2:    push_word = {data_word[31:16], 16'h8000};
							default: push_word = {data_word[31:8], 8'h80};
						endcase
					end
				end
			end
			S_PAD: begin
				push = 1'b1;
				if (pad_word_q) begin
					push_word = PAD_WORD;
				end else if (len_hi_q) begin
					push_word = {bytes_q[28:0], 3'b000};
				end else if (pos_q == LEN_HI_POS) begin
					push_word = bytes_q[60:29];
				end else begin
					push_word = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign full = push && (pos_q == LAST_POS);

	assign msg_ctrl.push   = push;
	assign msg_ctrl.expand = (state_q == S_COMP);
	assign rnd_ctrl.load   = full;
	assign rnd_ctrl.step   = (state_q == S_COMP);

	sm3_msg u_msg (
		.clk       (clk),
		.ctrl      (msg_ctrl),
		.push_word (push_word),
		.w_j       (w_j),
		.wp_j      (wp_j)
	);

	sm3_round u_round (
		.clk   (clk),
		.ctrl  (rnd_ctrl),
		.round (round_q),
		.chain (chain_q),
		.w_j   (w_j),
		.wp_j  (wp_j),
		.state (rnd_state)
	);

	// sequencer and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			chain_q    <= SM3_IV;
			pos_q      <= '0;
			bytes_q    <= '0;
			round_q    <= '0;
			idx_q      <= '0;
			pad_q      <= 1'b0;
			pad_word_q <= 1'b0;
			len_hi_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (full) begin
				round_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						bytes_q <= bytes_q + 61'(add_bytes);
						if (last) begin
							pad_q      <= 1'b1;
							pad_word_q <= byte_count[2];
							len_hi_q   <= 1'b0;
							done_q     <= 1'b0;
						end
						if (full) begin
							state_q <= S_COMP;
						end else if (last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (pad_word_q) begin
						pad_word_q <= 1'b0;
					end else if (len_hi_q) begin
						len_hi_q <= 1'b0;
						done_q   <= 1'b1;
					end else if (pos_q == LEN_HI_POS) begin
						len_hi_q <= 1'b1;
					end
					if (full) begin
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					// feed-forward into the chaining value
					chain_q <= chain_q ^ rnd_state;
					idx_q   <= '0;
					if (done_q) begin
						state_q <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							// back to a fresh message
							chain_q <= SM3_IV;
							bytes_q <= '0;
							pad_q   <= 1'b0;
							done_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digest only leaves with an empty block buffer
	`ASSERT_IMPL(a_out_pos_zero, clk, arst_n, digest_valid, pos_q == '0)
	// input and output sides never open together
	`ASSERT_ALWAYS(a_ready_excl, clk, arst_n, !(data_ready && digest_valid))
	// the lower length word always lands in the last slot
	`ASSERT_IMPL(a_len_lo_slot, clk, arst_n, (state_q == S_PAD) && len_hi_q, pos_q == LAST_POS)
	// compression ends in a fold after the last round
	`ASSERT_NEXT(a_comp_fold, clk, arst_n, (state_q == S_COMP) && (round_q == LAST_ROUND), state_q == S_FOLD)

endmodule

// ===== tb/sv/sm3_hash_test.sv =====
// testbench for sm3_hash: directed and random messages checked against a digest predictor
module sm3_hash_test;
	import sm3_pkg::word_t;

	// one digest transfer as seen on the output channel
	typedef struct packed {
		word_t      word;
		logic [2:0] idx;
		logic       fin;
	} digest_beat_t;

	// directed stimulus row: a word repeated reps times, digest typed in where known
	typedef struct {
		word_t       data;
		logic [2:0]  bcnt;
		logic        fin;
		int unsigned reps;
		logic        known;
		logic [255:0] digest;
	} stim_row_t;

	localparam logic [255:0] SM3_INIT =
		256'h7380166f_4914b2b9_172442d7_da8a0600_a96f30bc_163138aa_e38dee4d_b0fb0e4e;
	localparam word_t      T_EARLY       = 32'h79CC4519;
	localparam word_t      T_LATE        = 32'h7A879D8A;
	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam int         RANDOM_ITEMS  = 95;
	localparam int         DRAIN_CYCLES  = 200;
	localparam int         DIRECTED_ROWS = 10;

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// digest words still owed by the block, oldest first
	digest_beat_t pending_digest_q[$];
	int           mismatch_count = 0;
	int           items_sent = 0;
	int           burst_left = 0;

	// receiver stall pattern, reloaded each time the 5-bit pointer wraps
	logic [31:0] stall_bits = '1;
	logic [4:0]  stall_ptr = '0;

	// predictor state: chaining value, block buffer, fill position, byte count
	word_t       chain_w [8];
	word_t       block_w [16];
	logic [3:0]  fill_pos;
	logic [60:0] msg_bytes;

	// empty message, then "abc" with junk in the ignored low byte, both standard vectors;
	// the rest covers byte count extremes, ignored counts on inner words, and a
	// padding word landing in slot 14 so the length needs an extra block
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h00000000, 3'd0, 1'b1, 1, 1'b1,
			256'h1ab21d83_55cfa17f_8e611948_31e81a8f_22bec8c7_28fefb74_7ed035eb_5082aa2b},
		'{32'h616263a5, 3'd3, 1'b1, 1, 1'b1,
			256'h66c7f0f4_62eeedd9_d1f2d46b_dc10e4e2_4167c487_5cf2f7a2_297da02b_8f4ba8e0},
		'{32'hffffffff, 3'd4, 1'b1, 1, 1'b0, '0},
		'{32'h00000000, 3'd7, 1'b1, 1, 1'b0, '0},
		'{32'h12345678, 3'd5, 1'b1, 1, 1'b0, '0},
		'{32'hdeadbeef, 3'd0, 1'b0, 1, 1'b0, '0},
		'{32'hcafef00d, 3'd6, 1'b0, 1, 1'b0, '0},
		'{32'h89abcdef, 3'd1, 1'b1, 1, 1'b0, '0},
		'{32'ha5a5a5a5, 3'd4, 1'b0, 14, 1'b0, '0},
		'{32'h5a5a5a5a, 3'd2, 1'b1, 1, 1'b0, '0}
	};

	sm3_hash u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic word_t rol32(input word_t x, input int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic word_t mix_p0(input word_t x);
		return x ^ rol32(x, 9) ^ rol32(x, 17);
	endfunction

	function automatic word_t mix_p1(input word_t x);
		return x ^ rol32(x, 15) ^ rol32(x, 23);
	endfunction

	// 64-round compression of block_w into chain_w
	function automatic void sm3_compress();
		word_t w [68];
		word_t wx [64];
		word_t a, b, c, d, e, f, g, h;
		word_t a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = block_w[j];
		for (int j = 16; j < 68; j++)
			w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
		for (int j = 0; j < 64; j++)
			wx[j] = w[j] ^ w[j+4];
		a = chain_w[0]; b = chain_w[1]; c = chain_w[2]; d = chain_w[3];
		e = chain_w[4]; f = chain_w[5]; g = chain_w[6]; h = chain_w[7];
		for (int j = 0; j < 64; j++) begin
			a12 = rol32(a, 12);
			// round constant rotation wraps at 32
			ss1 = rol32(a12 + e + rol32((j < 16) ? T_EARLY : T_LATE, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + wx[j];
			tt2 = gg + h + ss1 + w[j];
			d = c;
			c = rol32(b, 9);
			b = a;
			a = tt1;
			h = g;
			g = rol32(f, 19);
			f = e;
			e = mix_p0(tt2);
		end
		chain_w[0] ^= a; chain_w[1] ^= b; chain_w[2] ^= c; chain_w[3] ^= d;
		chain_w[4] ^= e; chain_w[5] ^= f; chain_w[6] ^= g; chain_w[7] ^= h;
	endfunction

	function automatic void absorb_word(input word_t w);
		block_w[fill_pos] = w;
		fill_pos = fill_pos + 4'd1;
		if (fill_pos == 4'd0)
			sm3_compress();
	endfunction

	function automatic void reset_predictor();
		for (int k = 0; k < 8; k++)
			chain_w[k] = SM3_INIT[255 - 32*k -: 32];
		fill_pos = '0;
		msg_bytes = '0;
	endfunction

	// takes one input word; returns 1 with the digest when the word closes a message
	function automatic bit predict_hash_item(input word_t data, input logic [2:0] bc,
			input logic fin, output logic [255:0] digest);
		int unsigned nb;
		word_t       kept;
		logic [63:0] bit_len;
		digest = '0;
		if (!fin) begin
			// byte count ignored on inner words
			absorb_word(data);
			msg_bytes = msg_bytes + 61'd4;
			return 1'b0;
		end
		// counts above four act as four
		nb = (bc > 3'd4) ? 4 : int'(bc);
		msg_bytes = msg_bytes + 61'(nb);
		if (nb == 4) begin
			absorb_word(data);
			absorb_word({PAD_BYTE, 24'h0});
		end else begin
			// bytes beyond the count are dropped, pad byte follows the last valid one
			kept = (nb == 0) ? '0 : data & (32'hffffffff << (32 - 8*nb));
			absorb_word(kept | (32'(PAD_BYTE) << (24 - 8*nb)));
		end
		while (fill_pos != 4'd14)
			absorb_word('0);
		bit_len = {msg_bytes, 3'b000};
		absorb_word(bit_len[63:32]);
		absorb_word(bit_len[31:0]);
		for (int k = 0; k < 8; k++)
			digest[255 - 32*k -: 32] = chain_w[k];
		reset_predictor();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// receiver: check each digest transfer, then pick next ready from the stall pattern
	always @(posedge clk) begin
		digest_beat_t want;
		if (!arst_n) begin
			digest_ready <= 1'b0;
		end else begin
			if (digest_valid === 1'b1 && digest_ready) begin
				if (pending_digest_q.size() == 0) begin
					report_mismatch($sformatf("digest transfer %h with nothing pending",
						digest_word));
				end else begin
					want = pending_digest_q.pop_front();
					if (digest_word !== want.word)
						report_mismatch($sformatf("digest_word %0d: expected %h got %h",
							want.idx, want.word, digest_word));
					if (word_index !== want.idx)
						report_mismatch($sformatf("word_index: expected %0d got %0d",
							want.idx, word_index));
					if (last_word !== want.fin)
						report_mismatch($sformatf("last_word at index %0d: expected %b got %b",
							want.idx, want.fin, last_word));
				end
			end
			digest_ready <= stall_bits[stall_ptr];
			stall_ptr <= stall_ptr + 5'd1;
			// new pattern: free running, random, mostly stalled, or mostly ready
			if (stall_ptr == 5'd31) begin
				case ($urandom_range(0, 3))
				0: stall_bits <= '1;
				1: stall_bits <= $urandom;
				2: stall_bits <= $urandom & $urandom;
				default: stall_bits <= $urandom | $urandom;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// present one word, wait for its transfer, record expected digest, then pace the burst
	task automatic send_item(input word_t d, input logic [2:0] bc, input logic fin,
			input logic known, input logic [255:0] typed);
		logic [255:0] digest;
		data_word  <= d;
		byte_count <= bc;
		last       <= fin;
		data_valid <= 1'b1;
		do @(posedge clk); while (data_ready !== 1'b1);
		if (predict_hash_item(d, bc, fin, digest)) begin
			// standard vectors are checked against the typed digest
			if (known)
				digest = typed;
			for (int k = 0; k < 8; k++)
				pending_digest_q.push_back(digest_beat_t'{digest[255 - 32*k -: 32],
					3'(k), k == 7});
		end
		items_sent++;
		// end of burst: drop valid for a gap, sometimes long enough to span a compression
		if (burst_left == 0) begin
			data_valid <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8))
				@(posedge clk);
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		int directed_items;
		int msg_words;
		arst_n     <= 1'b0;
		data_valid <= 1'b0;
		data_word  <= '0;
		byte_count <= '0;
		last       <= 1'b0;
		reset_predictor();
		for (int k = 0; k < 16; k++)
			block_w[k] = '0;
		burst_left = $urandom_range(0, 24);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			repeat (directed_rows[r].reps)
				send_item(directed_rows[r].data, directed_rows[r].bcnt, directed_rows[r].fin,
					directed_rows[r].known, directed_rows[r].digest);
		directed_items = items_sent;

		// random messages: mostly short, many around one block so padding spills over,
		// a few spanning two blocks
		while (items_sent < directed_items + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
			0: msg_words = $urandom_range(28, 33);
			1, 2, 3: msg_words = $urandom_range(12, 17);
			default: msg_words = $urandom_range(0, 6);
			endcase
			repeat (msg_words)
				send_item($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
			send_item($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
		end
		if (data_valid)
			data_valid <= 1'b0;

		while (pending_digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("timeout with %0d digest words pending", pending_digest_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
